// ----- sv/ofe_pkg.sv -----
`default_nettype none

package ofe_pkg;

    // Width of one stored vertex index.
    localparam int unsigned VERTEX_W = 32;

    // Saturation point of the digit magnitude, and the index stored for an empty token.
    localparam logic [VERTEX_W-1:0] MAG_LIMIT   = 32'h8000_0000;
    localparam logic [VERTEX_W-1:0] EMPTY_INDEX = 32'hFFFF_FFFF;

    // What one accepted byte asks of the face store.
    typedef struct packed {
        logic write;   // at least one entry is to be appended
        logic commit;  // entries take the parsed number, otherwise the empty index
        logic close;   // the line ends with this byte
    } ofe_tok_cmd_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch the token command of the accepted byte
        logic fill;       // append one entry to the face store
        logic start;      // begin the edge walk: read entry zero
        logic head;       // capture entry zero as ring head and first vertex
        logic edge_load;  // load the output register with the current edge
        logic advance;    // step to the next edge
        logic clear;      // empty the face after the closing edge
    } ofe_dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_last;   // this append is the last one of the command
        logic face_empty;  // no vertex is stored
        logic last_edge;   // the output register holds the closing edge
    } ofe_dp_sts_t;

endpackage

`default_nettype wire

// ----- sv/ofe_parser.sv -----
`default_nettype none

module ofe_parser #(
    parameter int unsigned MAX_FACE_VERTICES = 16,
    localparam int unsigned CW = $clog2(MAX_FACE_VERTICES + 1)
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           byte_accept,
    input  wire logic [7:0]                     ch_in,
    input  wire logic                           end_of_input,
    input  wire logic                           face_full,
    output ofe_pkg::ofe_tok_cmd_t               tok_cmd,
    output logic [CW-1:0]                       tok_rep,
    output logic [ofe_pkg::VERTEX_W-1:0]        tok_value
);

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_F     = 8'd102;

    localparam logic [CW-1:0] PEND_MAX = CW'(MAX_FACE_VERTICES);

    typedef enum logic [7:0] {
        PH_LINE_START = 8'b0000_0001,
        PH_AFTER_F    = 8'b0000_0010,
        PH_GAP        = 8'b0000_0100,
        PH_LEAD       = 8'b0000_1000,
        PH_SIGN       = 8'b0001_0000,
        PH_DIGITS     = 8'b0010_0000,
        PH_SKIP       = 8'b0100_0000,
        PH_IGNORE     = 8'b1000_0000
    } phase_t;

    phase_t                         phase_reg, phase_next, ph_mid;
    logic [ofe_pkg::VERTEX_W-1:0]   acc_reg, acc_next, acc_dig, acc_first;
    logic                           neg_reg, neg_next;
    logic [CW-1:0]                  pend_reg, pend_next, pend_mid, pend_bump;
    logic                           crossed_reg, crossed_next;
    logic [CW-1:0]                  rep;
    logic                           commit;
    logic                           is_digit, is_sign, is_ows, is_space, line_end;

    // Magnitude times ten plus one digit, saturated at the magnitude limit.
    function automatic logic [ofe_pkg::VERTEX_W-1:0] mac10(
        input logic [ofe_pkg::VERTEX_W-1:0] a,
        input logic [3:0]                   d
    );
        logic [35:0] s;
        s = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {32'd0, d};
        return (s > {4'd0, ofe_pkg::MAG_LIMIT}) ? ofe_pkg::MAG_LIMIT : s[31:0];
    endfunction

    // Byte classes.
    assign is_digit  = (ch_in >= CH_ZERO) && (ch_in <= CH_NINE);
    assign is_sign   = (ch_in == CH_PLUS) || (ch_in == CH_MINUS);
    assign is_ows    = (ch_in == CH_TAB) || (ch_in == CH_VT) || (ch_in == CH_FF)
                       || (ch_in == CH_CR);
    assign is_space  = (ch_in == CH_SP);
    assign line_end  = (ch_in == CH_NL) || end_of_input;
    assign acc_dig   = mac10(acc_reg, ch_in[3:0]);
    assign acc_first = {28'd0, ch_in[3:0]};
    assign pend_bump = (crossed_reg && (pend_reg < PEND_MAX)) ? pend_reg + CW'(1) : pend_reg;

    // Token parsing of one byte, then the token close at the end of the line.
    always_comb begin
        ph_mid       = phase_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        pend_mid     = pend_reg;
        crossed_next = crossed_reg;
        rep          = '0;
        commit       = 1'b0;
        if (ch_in != CH_NL) begin
            if (ch_in == CH_NUL) begin
                if (phase_reg == PH_DIGITS) begin
                    rep    = CW'(1);
                    commit = 1'b1;
                end else if ((phase_reg == PH_LEAD) || (phase_reg == PH_SIGN)) begin
                    rep = pend_reg;
                end
                pend_mid = '0;
                ph_mid   = PH_IGNORE;
            end else begin
                case (phase_reg)
                    PH_LINE_START: begin
                        ph_mid = (ch_in == CH_F) ? PH_AFTER_F : PH_IGNORE;
                    end
                    PH_AFTER_F: begin
                        ph_mid = is_space ? PH_GAP : PH_IGNORE;
                    end
                    PH_GAP: begin
                        if (is_space) begin
                            ph_mid = PH_GAP;
                        end else if (face_full) begin
                            ph_mid = PH_IGNORE;
                        end else begin
                            acc_next = '0;
                            neg_next = 1'b0;
                            if (is_digit) begin
                                acc_next = acc_first;
                                ph_mid   = PH_DIGITS;
                            end else if (is_sign) begin
                                neg_next = (ch_in == CH_MINUS);
                                pend_mid = CW'(1);
                                ph_mid   = PH_SIGN;
                            end else if (is_ows) begin
                                pend_mid     = CW'(1);
                                crossed_next = 1'b0;
                                ph_mid       = PH_LEAD;
                            end else begin
                                rep    = CW'(1);
                                ph_mid = PH_SKIP;
                            end
                        end
                    end
                    PH_LEAD: begin
                        if (is_space) begin
                            crossed_next = 1'b1;
                        end else if (is_ows) begin
                            pend_mid     = pend_bump;
                            crossed_next = 1'b0;
                        end else if (is_digit) begin
                            pend_mid = '0;
                            acc_next = acc_first;
                            neg_next = 1'b0;
                            ph_mid   = PH_DIGITS;
                        end else if (is_sign) begin
                            pend_mid = pend_bump;
                            neg_next = (ch_in == CH_MINUS);
                            acc_next = '0;
                            ph_mid   = PH_SIGN;
                        end else begin
                            rep      = pend_bump;
                            pend_mid = '0;
                            ph_mid   = PH_SKIP;
                        end
                    end
                    PH_SIGN: begin
                        if (is_digit) begin
                            pend_mid = '0;
                            acc_next = acc_dig;
                            ph_mid   = PH_DIGITS;
                        end else begin
                            rep      = pend_reg;
                            pend_mid = '0;
                            ph_mid   = is_space ? PH_GAP : PH_SKIP;
                        end
                    end
                    PH_DIGITS: begin
                        if (is_digit) begin
                            acc_next = acc_dig;
                        end else begin
                            rep    = CW'(1);
                            commit = 1'b1;
                            ph_mid = is_space ? PH_GAP : PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        if (is_space) begin
                            ph_mid = PH_GAP;
                        end
                    end
                    PH_IGNORE: begin
                        ph_mid = PH_IGNORE;
                    end
                    default: begin
                        ph_mid = PH_IGNORE;
                    end
                endcase
            end
        end

        phase_next = ph_mid;
        pend_next  = pend_mid;
        if (line_end) begin
            // A token still open at the line end is finished here.
            if (ph_mid == PH_DIGITS) begin
                rep    = CW'(1);
                commit = 1'b1;
            end else if ((ph_mid == PH_LEAD) || (ph_mid == PH_SIGN)) begin
                rep    = pend_mid;
                commit = 1'b0;
            end
            phase_next   = PH_LINE_START;
            pend_next    = '0;
            crossed_next = 1'b0;
        end
    end

    assign tok_rep        = rep;
    assign tok_cmd.write  = (rep != '0);
    assign tok_cmd.commit = commit;
    assign tok_cmd.close  = line_end;

    // Stored index: the signed value minus one, saturated to 32 bits.
    always_comb begin
        if (neg_reg) begin
            tok_value = acc_reg[31] ? ofe_pkg::MAG_LIMIT : ~acc_reg;
        end else begin
            tok_value = acc_reg[31] ? 32'h7FFF_FFFE : acc_reg - 32'd1;
        end
    end

    // Parser state advances on each accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LINE_START;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            pend_reg    <= '0;
            crossed_reg <= 1'b0;
        end else if (byte_accept) begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            pend_reg    <= pend_next;
            crossed_reg <= crossed_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/ofe_datapath.sv -----
`default_nettype none

module ofe_datapath #(
    parameter int unsigned MAX_FACE_VERTICES = 16,
    localparam int unsigned CW = $clog2(MAX_FACE_VERTICES + 1),
    localparam int unsigned AW = $clog2(MAX_FACE_VERTICES)
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire ofe_pkg::ofe_dp_cmd_t           dp_cmd,
    input  wire logic [CW-1:0]                  tok_rep,
    input  wire logic                           tok_commit,
    input  wire logic [ofe_pkg::VERTEX_W-1:0]   tok_value,
    output ofe_pkg::ofe_dp_sts_t                dp_sts,
    output logic                                face_full,
    output logic [2*ofe_pkg::VERTEX_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    localparam int unsigned PW = CW + 1;

    logic [ofe_pkg::VERTEX_W-1:0] face_mem [MAX_FACE_VERTICES];
    logic [CW-1:0]                rep_reg;
    logic                         commit_reg;
    logic [CW-1:0]                count_reg;
    logic [AW-1:0]                pos_reg;
    logic [ofe_pkg::VERTEX_W-1:0] rd_data_reg, head_reg, first_reg, second_reg;
    logic                         last_reg;
    logic [PW-1:0]                pos_inc1, pos_inc2, cnt_ext;
    logic                         ring_end;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic                         wr_en;
    logic [ofe_pkg::VERTEX_W-1:0] wr_value;

    assign face_full = (count_reg == CW'(MAX_FACE_VERTICES));
    assign cnt_ext   = PW'(count_reg);
    assign pos_inc1  = PW'(pos_reg) + PW'(1);
    assign pos_inc2  = PW'(pos_reg) + PW'(2);
    assign ring_end  = (pos_inc1 == cnt_ext);
    assign wr_en     = dp_cmd.fill && !face_full;
    assign wr_value  = commit_reg ? tok_value : ofe_pkg::EMPTY_INDEX;

    // Read port address: entry zero, entry one, or the entry after the next edge.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (dp_cmd.start) begin
            rd_en = 1'b1;
        end else if (dp_cmd.head) begin
            rd_en   = (cnt_ext > PW'(1));
            rd_addr = AW'(1);
        end else if (dp_cmd.advance) begin
            rd_en   = (pos_inc2 < cnt_ext);
            rd_addr = pos_inc2[AW-1:0];
        end
    end

    assign dp_sts.fill_last  = (rep_reg <= CW'(1)) || face_full;
    assign dp_sts.face_empty = (count_reg == '0);
    assign dp_sts.last_edge  = last_reg;

    // Face store: one append port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            face_mem[count_reg[AW-1:0]] <= wr_value;
        end
        if (rd_en) begin
            rd_data_reg <= face_mem[rd_addr];
        end
    end

    // Fill count, pending appends and edge position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            rep_reg   <= '0;
            pos_reg   <= '0;
        end else begin
            if (dp_cmd.clear) begin
                count_reg <= '0;
            end else if (wr_en) begin
                count_reg <= count_reg + CW'(1);
            end
            if (dp_cmd.load) begin
                rep_reg <= tok_rep;
            end else if (dp_cmd.fill && (rep_reg != '0)) begin
                rep_reg <= rep_reg - CW'(1);
            end
            if (dp_cmd.start) begin
                pos_reg <= '0;
            end else if (dp_cmd.advance) begin
                pos_reg <= pos_inc1[AW-1:0];
            end
        end
    end

    // Token kind and the output edge register.
    always_ff @(posedge aclk) begin
        if (dp_cmd.load) begin
            commit_reg <= tok_commit;
        end
        if (dp_cmd.head) begin
            head_reg  <= rd_data_reg;
            first_reg <= rd_data_reg;
        end else if (dp_cmd.advance) begin
            first_reg <= second_reg;
        end
        if (dp_cmd.edge_load) begin
            second_reg <= ring_end ? head_reg : rd_data_reg;
            last_reg   <= ring_end;
        end
    end

    assign m_tdata = {second_reg, first_reg};
    assign m_tlast = last_reg;

endmodule

`default_nettype wire

// ----- sv/ofe_ctrl.sv -----
`default_nettype none

module ofe_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire ofe_pkg::ofe_tok_cmd_t  tok_cmd,
    input  wire ofe_pkg::ofe_dp_sts_t   dp_sts,
    output ofe_pkg::ofe_dp_cmd_t        dp_cmd
);

    typedef enum logic [5:0] {
        ST_RUN   = 6'b00_0001,
        ST_FILL  = 6'b00_0010,
        ST_CLOSE = 6'b00_0100,
        ST_HEAD  = 6'b00_1000,
        ST_EDGE  = 6'b01_0000,
        ST_OUT   = 6'b10_0000
    } state_t;

    state_t state_reg, state_next;
    logic   close_reg, close_next;
    logic   accept;

    assign s_tready = (state_reg == ST_RUN);
    assign m_tvalid = (state_reg == ST_OUT);
    assign accept   = s_tvalid && s_tready;

    // Sequencing of byte transfers, store appends and the edge walk.
    always_comb begin
        state_next = state_reg;
        close_next = close_reg;
        dp_cmd     = '0;
        dp_cmd.load = accept;
        case (state_reg)
            ST_RUN: begin
                if (accept) begin
                    close_next = tok_cmd.close;
                    if (tok_cmd.write) begin
                        state_next = ST_FILL;
                    end else if (tok_cmd.close) begin
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_FILL: begin
                dp_cmd.fill = 1'b1;
                if (dp_sts.fill_last) begin
                    state_next = close_reg ? ST_CLOSE : ST_RUN;
                end
            end
            ST_CLOSE: begin
                if (dp_sts.face_empty) begin
                    state_next = ST_RUN;
                end else begin
                    dp_cmd.start = 1'b1;
                    state_next   = ST_HEAD;
                end
            end
            ST_HEAD: begin
                dp_cmd.head = 1'b1;
                state_next  = ST_EDGE;
            end
            ST_EDGE: begin
                dp_cmd.edge_load = 1'b1;
                state_next       = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (dp_sts.last_edge) begin
                        dp_cmd.clear = 1'b1;
                        state_next   = ST_RUN;
                    end else begin
                        dp_cmd.advance = 1'b1;
                        state_next     = ST_EDGE;
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            close_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            close_reg <= close_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/obj_face_edge_extractor_unit.sv -----
// Flow: a byte that appends entries to the face store holds the input while the fill state
// appends them one at a time. A line end then walks the face: the close and head states fetch
// the ring head, the edge state loads each edge, the output state holds it until m_tready.
// Throughput: one byte per cycle while no token completes and no line ends; an empty face
// returns straight to taking bytes. Reset: aresetn is synchronous and active low; it returns
// the parser to line start and empties the face. The face store contents are not cleared.
`default_nettype none

module obj_face_edge_extractor_unit #(
    parameter int unsigned MAX_FACE_VERTICES = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,   // [7:0] ch
    input  wire logic           s_tlast,   // end_of_input
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [63:0]         m_tdata,   // [31:0] first_vertex, [63:32] second_vertex
    output logic                m_tlast    // last_of_face
);

    localparam int unsigned CW = $clog2(MAX_FACE_VERTICES + 1);

    ofe_pkg::ofe_tok_cmd_t          tok_cmd;
    ofe_pkg::ofe_dp_cmd_t           dp_cmd;
    ofe_pkg::ofe_dp_sts_t           dp_sts;
    logic [CW-1:0]                  tok_rep;
    logic [ofe_pkg::VERTEX_W-1:0]   tok_value;
    logic                           face_full;
    logic                           byte_accept;

    assign byte_accept = s_tvalid && s_tready;

    ofe_parser #(
        .MAX_FACE_VERTICES (MAX_FACE_VERTICES)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_accept  (byte_accept),
        .ch_in        (s_tdata),
        .end_of_input (s_tlast),
        .face_full    (face_full),
        .tok_cmd      (tok_cmd),
        .tok_rep      (tok_rep),
        .tok_value    (tok_value)
    );

    ofe_datapath #(
        .MAX_FACE_VERTICES (MAX_FACE_VERTICES)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dp_cmd     (dp_cmd),
        .tok_rep    (tok_rep),
        .tok_commit (tok_cmd.commit),
        .tok_value  (tok_value),
        .dp_sts     (dp_sts),
        .face_full  (face_full),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    ofe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .tok_cmd  (tok_cmd),
        .dp_sts   (dp_sts),
        .dp_cmd   (dp_cmd)
    );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int unsigned FACE_MAX = 16;
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned BYTES_PER_PHASE = 90;
    localparam int unsigned LONG_HOLD = 400;

    // Character codes the face parser reacts to.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_HIGH  = 8'hFF;

    typedef enum logic [2:0] {
        PS_LINE_START,
        PS_AFTER_F,
        PS_GAP,
        PS_LEAD,
        PS_SIGN,
        PS_DIGITS,
        PS_SKIP,
        PS_IGNORE
    } parse_state_t;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
    } text_byte_t;

    typedef struct {
        logic [ofe_pkg::VERTEX_W-1:0] v_from;
        logic [ofe_pkg::VERTEX_W-1:0] v_to;
        logic                         closing;
    } face_edge_t;

    // Block ports.
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] ch
    logic        s_tlast = 1'b0; // end_of_input
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // [31:0] first_vertex, [63:32] second_vertex
    logic        m_tlast;        // last_of_face

    // Stimulus queue and flow control knobs.
    text_byte_t text_q[$];
    text_byte_t cur_byte;
    logic       byte_taken = 1'b0;
    logic       nxt_valid;
    int         bytes_queued = 0;
    int         bytes_taken = 0;
    int         tx_idle_pct = 0;
    int         rx_stall_pct = 0;
    int         rx_hold_left = 0;
    int         cycle_count = 0;
    int         err_count = 0;

    // Predictor state of the face parser.
    parse_state_t                 ps = PS_LINE_START;
    logic [ofe_pkg::VERTEX_W-1:0] mag = '0;
    logic                         mag_neg = 1'b0;
    logic [ofe_pkg::VERTEX_W-1:0] verts[FACE_MAX];
    int                           nverts = 0;
    int                           empties_owed = 0;
    logic                         space_seen = 1'b0;
    face_edge_t                   pending_edges[$];
    face_edge_t                   edge_want;

    logic [7:0] ws_set[4] = '{CH_TAB, CH_VT, CH_FF, CH_CR};

    obj_face_edge_extractor_unit #(
        .MAX_FACE_VERTICES(FACE_MAX)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Face parser prediction
    // ------------------------------------------------------------------

    function automatic bit is_digit_ch(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_sign_ch(logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic bit is_ws_ch(logic [7:0] c);
        return c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    function automatic void append_vertex(logic [ofe_pkg::VERTEX_W-1:0] v);
        if (nverts < FACE_MAX) begin
            verts[nverts] = v;
            nverts++;
        end
    endfunction

    function automatic void append_empties(int n);
        for (int i = 0; i < n && i < FACE_MAX; i++) append_vertex(ofe_pkg::EMPTY_INDEX);
    endfunction

    function automatic void owe_empty();
        if (empties_owed < FACE_MAX) empties_owed++;
    endfunction

    // Magnitude grows by one decimal digit and saturates at 2^31.
    function automatic void add_digit(logic [7:0] c);
        logic [63:0] m;
        logic [63:0] dval;
        dval = {56'd0, c - CH_ZERO};
        m = {32'd0, mag} * 64'd10 + dval;
        mag = (m > {32'd0, ofe_pkg::MAG_LIMIT}) ? ofe_pkg::MAG_LIMIT : m[31:0];
    endfunction

    // Signed value clamped to 32 bits, then made zero based.
    function automatic void commit_number();
        longint v;
        v = longint'({32'd0, mag});
        if (mag_neg) v = -v;
        else if (v > 64'sd2147483647) v = 64'sd2147483647;
        v = v - 1;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        append_vertex(v[31:0]);
    endfunction

    function automatic void close_token();
        if (ps == PS_DIGITS) commit_number();
        else if (ps == PS_LEAD || ps == PS_SIGN) append_empties(empties_owed);
        empties_owed = 0;
    endfunction

    function automatic void open_token(logic [7:0] c);
        mag = '0;
        mag_neg = 1'b0;
        if (is_digit_ch(c)) begin
            add_digit(c);
            ps = PS_DIGITS;
        end else if (is_sign_ch(c)) begin
            mag_neg = (c == CH_MINUS);
            empties_owed = 1;
            ps = PS_SIGN;
        end else if (is_ws_ch(c)) begin
            empties_owed = 1;
            space_seen = 1'b0;
            ps = PS_LEAD;
        end else begin
            append_vertex(ofe_pkg::EMPTY_INDEX);
            ps = PS_SKIP;
        end
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        if (c == CH_NUL) begin
            // A NUL stops parsing; the face closes at the line end.
            close_token();
            ps = PS_IGNORE;
            return;
        end
        case (ps)
            PS_LINE_START: ps = (c == CH_F) ? PS_AFTER_F : PS_IGNORE;
            PS_AFTER_F: begin
                if (c == CH_SPACE) begin
                    nverts = 0;
                    ps = PS_GAP;
                end else begin
                    ps = PS_IGNORE;
                end
            end
            PS_GAP: begin
                if (c != CH_SPACE) begin
                    if (nverts >= FACE_MAX) ps = PS_IGNORE;
                    else open_token(c);
                end
            end
            PS_LEAD: begin
                // strtol-style search for digits across spaces after leading whitespace.
                if (c == CH_SPACE) begin
                    space_seen = 1'b1;
                end else if (is_ws_ch(c)) begin
                    if (space_seen) owe_empty();
                    space_seen = 1'b0;
                end else if (is_digit_ch(c)) begin
                    empties_owed = 0;
                    mag = '0;
                    mag_neg = 1'b0;
                    add_digit(c);
                    ps = PS_DIGITS;
                end else if (is_sign_ch(c)) begin
                    if (space_seen) owe_empty();
                    mag_neg = (c == CH_MINUS);
                    mag = '0;
                    ps = PS_SIGN;
                end else begin
                    if (space_seen) owe_empty();
                    append_empties(empties_owed);
                    empties_owed = 0;
                    ps = PS_SKIP;
                end
            end
            PS_SIGN: begin
                if (is_digit_ch(c)) begin
                    empties_owed = 0;
                    add_digit(c);
                    ps = PS_DIGITS;
                end else begin
                    append_empties(empties_owed);
                    empties_owed = 0;
                    ps = (c == CH_SPACE) ? PS_GAP : PS_SKIP;
                end
            end
            PS_DIGITS: begin
                if (is_digit_ch(c)) begin
                    add_digit(c);
                end else begin
                    commit_number();
                    ps = (c == CH_SPACE) ? PS_GAP : PS_SKIP;
                end
            end
            PS_SKIP: if (c == CH_SPACE) ps = PS_GAP;
            default: ;
        endcase
    endfunction

    // One accepted byte; a line end turns the stored indices into a ring of edges.
    function automatic void predict_byte(logic [7:0] c, logic eoi);
        face_edge_t e;
        if (c != CH_NL) scan_byte(c);
        if (c == CH_NL || eoi) begin
            close_token();
            for (int p = 0; p < nverts; p++) begin
                e.v_from = verts[p];
                e.v_to = verts[(p + 1 >= nverts) ? 0 : p + 1];
                e.closing = (p + 1 == nverts);
                pending_edges.push_back(e);
            end
            nverts = 0;
            empties_owed = 0;
            space_seen = 1'b0;
            mag = '0;
            mag_neg = 1'b0;
            ps = PS_LINE_START;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    task automatic push_byte(logic [7:0] c, logic eoi = 1'b0);
        text_byte_t b;
        b.ch = c;
        b.eoi = eoi;
        text_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    // Any byte but a newline.
    function automatic logic [7:0] junk_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == CH_NL);
        return c;
    endfunction

    function automatic logic [7:0] pick_ws();
        return ws_set[$urandom_range(3)];
    endfunction

    function automatic logic [7:0] pick_sign();
        return $urandom_range(1) ? CH_MINUS : CH_PLUS;
    endfunction

    task automatic push_digits(int n);
        for (int i = 0; i < n; i++) push_byte(CH_ZERO + 8'($urandom_range(9)));
    endtask

    // Mostly short numbers; now and then a long one, which may saturate.
    task automatic push_number();
        int r;
        r = $urandom_range(99);
        if (r < 12) push_byte(CH_MINUS);
        else if (r < 20) push_byte(CH_PLUS);
        if ($urandom_range(9) == 0) push_digits($urandom_range(12, 9));
        else push_digits($urandom_range(3, 1));
    endtask

    task automatic push_token();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            push_number();
        end else if (r < 65) begin
            // Sign with no digit behind it.
            push_byte(pick_sign());
            if ($urandom_range(3) == 0) push_byte(junk_byte());
        end else if (r < 82) begin
            // Whitespace-led run, with or without digits at its end.
            push_byte(pick_ws());
            repeat ($urandom_range(2)) begin
                repeat ($urandom_range(2)) push_byte(CH_SPACE);
                push_byte(pick_ws());
            end
            repeat ($urandom_range(2)) push_byte(CH_SPACE);
            case ($urandom_range(3))
                0: push_number();
                1: push_byte(junk_byte());
                2: push_byte(pick_sign());
                default: ;
            endcase
        end else if (r < 96) begin
            repeat ($urandom_range(3, 1)) push_byte(junk_byte());
        end else begin
            push_byte(CH_NUL);
            repeat ($urandom_range(3)) push_byte(junk_byte());
        end
    endtask

    // One line of text: mostly face lines, the rest other lines and noise.
    task automatic push_line();
        int r;
        int ntok;
        r = $urandom_range(99);
        if (r < 74) begin
            push_text("f ");
            if ($urandom_range(3) == 0) repeat ($urandom_range(2, 1)) push_byte(CH_SPACE);
            ntok = ($urandom_range(9) == 0) ? $urandom_range(20, 15) : $urandom_range(6);
            for (int t = 0; t < ntok; t++) begin
                if (t > 0) repeat (($urandom_range(4) == 0) ? 2 : 1) push_byte(CH_SPACE);
                push_token();
            end
            if ($urandom_range(4) == 0) push_byte(CH_SPACE);
        end else if (r < 88) begin
            repeat ($urandom_range(8, 1)) push_byte(junk_byte());
        end else begin
            push_byte(CH_F);
            push_byte(junk_byte());
            repeat ($urandom_range(4)) push_byte(junk_byte());
        end
        // Close with a newline, or with the end-of-input flag on the last byte.
        if ($urandom_range(6) == 0) text_q[$].eoi = 1'b1;
        else push_byte(CH_NL, ($urandom_range(7) == 0));
    endtask

    // Directed lines: plain ring, single index, empty face, other line,
    // saturation both ways, lone signs, whitespace runs, NUL, overflow, end of input.
    task automatic push_directed();
        push_text("f 1 2 3");
        push_byte(CH_NL);
        push_text("f 7");
        push_byte(CH_NL);
        push_text("f ");
        push_byte(CH_NL);
        push_text("v 1 2");
        push_byte(CH_NL);
        push_text("f 4294967296 -2147483649 +0 - +");
        push_byte(CH_TAB);
        push_text("  9 x");
        push_byte(CH_HIGH);
        push_byte(CH_NL);
        push_text("f ");
        push_byte(CH_CR);
        push_byte(CH_SPACE);
        push_byte(CH_VT);
        push_text("  ");
        push_byte(CH_FF);
        push_text(" q 5");
        push_byte(CH_NUL);
        push_text(" 8");
        push_byte(CH_NL);
        push_text("f 1 2 3 4 5 6 7 8 9 10 11 12 13 14 15 16 17");
        push_byte(CH_NL);
        push_text("f 2147483647 8");
        text_q[$].eoi = 1'b1;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (bytes_taken != bytes_queued || pending_edges.size() != 0);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        err_count++;
        if (err_count <= 40)
            $display("mismatch at cycle %0d: %s got %h expected %h",
                     cycle_count, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Input driver: one byte per transfer, changed on the falling edge.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || byte_taken)) begin
            nxt_valid = 1'b0;
            if (text_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                cur_byte = text_q.pop_front();
                nxt_valid = 1'b1;
                s_tdata <= cur_byte.ch;
                s_tlast <= cur_byte.eoi;
            end
            s_tvalid <= nxt_valid;
        end
        byte_taken = 1'b0;
    end

    // Result side ready, with random stalls and an occasional long hold-off.
    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Each accepted byte goes through the predictor.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_byte(s_tdata, s_tlast);
            bytes_taken++;
            byte_taken = 1'b1;
        end
    end

    // Result monitor: compare each edge transfer with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_edges.size() == 0) begin
                report_mismatch("edge with none pending", m_tdata[31:0], m_tdata[63:32]);
            end else begin
                edge_want = pending_edges.pop_front();
                if (m_tdata[31:0] !== edge_want.v_from)
                    report_mismatch("first_vertex", m_tdata[31:0], edge_want.v_from);
                if (m_tdata[63:32] !== edge_want.v_to)
                    report_mismatch("second_vertex", m_tdata[63:32], edge_want.v_to);
                if (m_tlast !== edge_want.closing)
                    report_mismatch("last_of_face", {31'd0, m_tlast}, {31'd0, edge_want.closing});
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Test sequence: reset, directed lines, then four random phases.
    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        push_directed();
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                    // Hold the result side off so the face store backs up into the input.
                    rx_hold_left = LONG_HOLD;
                end
                1: begin
                    tx_idle_pct = 54;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 54;
                end
                default: begin
                    tx_idle_pct = 8;
                    rx_stall_pct = 8;
                end
            endcase
            while (bytes_queued < BYTES_PER_PHASE * (ph + 1) + 150) push_line();
            // The sender stays quiet until every edge of the phase has come out.
            wait_drained();
        end

        repeat (120) @(posedge aclk);
        if (pending_edges.size() != 0)
            report_mismatch("edges never seen", pending_edges.size(), 0);
        if (err_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/ofe_pkg.sv
sv/ofe_parser.sv
sv/ofe_datapath.sv
sv/ofe_ctrl.sv
sv/obj_face_edge_extractor_unit.sv
bench/tb.sv
